/* hw/rtl/skt_pkg.sv */
// Package for the sorted key table: request and response structs, command,
// status and register codes, and default sizes.
// No dependencies; the table and the checker take names from here by scope.
package skt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 6;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_KEY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BEFORE     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SORTED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_DUP   = 1'd1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic [POS_W-1:0]  position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
    } t_rsp;

endpackage

/* hw/rtl/skt_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sorted_key_table.sv */
// Sorted key table: up to CAPACITY keys in one RAM with an entry count, driven by
// commands (insert, remove at index, remove key, find, read, entry before key, clear).
// A command is taken when start is high and busy is low; its single response shows on
// o_rsp for exactly one cycle with o_done, and busy drops in that same cycle, so the
// receiver must take it then. Every RAM access goes through one read port and one key
// comparator, one entry per cycle, and that sets the pace of each command: clear, an
// unused code and a bad position finish straight from idle, read at index issues one
// RAM read, a sorted search checks the first and last entries and then halves the range,
// an unsorted search scans the entries in order, and an insert or a remove moves the
// entries after the place one at a time. Depends on skt_pkg and skt_ram.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  skt_pkg::t_req                    i_req,
    output logic                             o_done,
    output skt_pkg::t_rsp                    o_rsp,
    input  logic                             i_cfg_we,
    input  logic [skt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [skt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = (CW > skt_pkg::POS_W) ? CW : skt_pkg::POS_W;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BS_FIRST,
        S_BS_LAST,
        S_BS_MID,
        S_PLACED,
        S_PCMP,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_SHIFT,
        S_RDV
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_keep_sorted;
    logic                       r_allow_dup;
    logic [CW-1:0]              r_count, n_count;
    logic [skt_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [KEY_BITS-1:0]        r_key, n_key;
    logic [CW-1:0]              r_at, n_at;
    logic [CW-1:0]              r_mid, n_mid;
    logic signed [SW-1:0]       r_low, n_low;
    logic signed [SW-1:0]       r_high, n_high;
    logic [AW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_left, n_left;
    logic                       r_rd_valid;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_done, n_done;
    skt_pkg::t_rsp              r_rsp, n_rsp;

    logic                       w_rd_issue;
    logic [AW-1:0]              w_rd_addr;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic [KEY_BITS-1:0]        w_wdata;
    logic [KEY_BITS-1:0]        w_rdata;
    logic                       w_gt;
    logic                       w_eq;
    logic [63:0]                w_key_ext;
    logic signed [SW-1:0]       w_mid_s;
    logic signed [SW-1:0]       w_nl;
    logic signed [SW-1:0]       w_nh;
    logic signed [SW-1:0]       w_sum;
    logic signed [SW-1:0]       w_nmid;

    function automatic logic [skt_pkg::IDX_W-1:0] f_idx(input logic [CW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[skt_pkg::IDX_W-1:0];
    endfunction

    function automatic logic [skt_pkg::CNT_W-1:0] f_cnt(input logic [CW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[skt_pkg::CNT_W-1:0];
    endfunction

    function automatic logic [skt_pkg::VAL_W-1:0] f_val(input logic [KEY_BITS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[skt_pkg::VAL_W-1:0];
    endfunction

    skt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // Shared comparator: held key against the entry read last cycle
    assign w_gt = r_key > w_rdata;
    assign w_eq = r_key == w_rdata;

    assign w_key_ext = {32'd0, i_req.key};

    // Binary search step: next bounds and midpoint
    assign w_mid_s = $signed({2'b00, r_mid});
    assign w_nl    = w_gt ? (w_mid_s + SW'(1)) : r_low;
    assign w_nh    = w_gt ? r_high : (w_mid_s - SW'(1));
    assign w_sum   = w_nl + w_nh;
    assign w_nmid  = w_sum >>> 1;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_kind     = r_kind;
        n_key      = r_key;
        n_at       = r_at;
        n_mid      = r_mid;
        n_low      = r_low;
        n_high     = r_high;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_done     = 1'b0;
        n_rsp      = '0;
        w_rd_issue = 1'b0;
        w_rd_addr  = r_ptr;
        w_we       = 1'b0;
        w_waddr    = r_rd_addr;
        w_wdata    = w_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_req.kind;
                    n_key  = w_key_ext[KEY_BITS-1:0];
                    unique case (i_req.kind)
                        skt_pkg::KIND_INSERT: begin
                            if (r_keep_sorted) begin
                                if (r_count == '0) begin
                                    n_at    = '0;
                                    n_state = S_PLACED;
                                end else begin
                                    w_rd_issue = 1'b1;
                                    w_rd_addr  = '0;
                                    n_state    = S_BS_FIRST;
                                end
                            end else if (NW'(i_req.position) > NW'(r_count)) begin
                                n_done       = 1'b1;
                                n_rsp.status = skt_pkg::ST_BADPOS;
                                n_state      = S_IDLE;
                            end else begin
                                n_at = CW'(i_req.position);
                                if (!r_allow_dup) begin
                                    n_ptr   = '0;
                                    n_left  = r_count;
                                    n_state = S_SCAN;
                                end else begin
                                    n_state = S_MISS;
                                end
                            end
                        end
                        skt_pkg::KIND_REMOVE_AT: begin
                            if (NW'(i_req.position) < NW'(r_count)) begin
                                n_at    = CW'(i_req.position);
                                n_left  = r_count - CW'(i_req.position) - CW'(1);
                                n_ptr   = AW'(i_req.position) + AW'(1);
                                n_state = S_SHIFT;
                            end else begin
                                n_done       = 1'b1;
                                n_rsp.status = skt_pkg::ST_BADPOS;
                            end
                        end
                        skt_pkg::KIND_REMOVE_KEY,
                        skt_pkg::KIND_FIND,
                        skt_pkg::KIND_BEFORE: begin
                            if (r_keep_sorted) begin
                                if (r_count == '0) begin
                                    n_at    = '0;
                                    n_state = S_PLACED;
                                end else begin
                                    w_rd_issue = 1'b1;
                                    w_rd_addr  = '0;
                                    n_state    = S_BS_FIRST;
                                end
                            end else begin
                                n_ptr   = '0;
                                n_left  = r_count;
                                n_state = S_SCAN;
                            end
                        end
                        skt_pkg::KIND_READ: begin
                            if (NW'(i_req.position) < NW'(r_count)) begin
                                n_at       = CW'(i_req.position);
                                w_rd_issue = 1'b1;
                                w_rd_addr  = AW'(i_req.position);
                                n_state    = S_RDV;
                            end else begin
                                n_done       = 1'b1;
                                n_rsp.status = skt_pkg::ST_BADPOS;
                            end
                        end
                        skt_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            S_BS_FIRST: begin
                if (!w_gt && !w_eq) begin
                    n_at    = '0;
                    n_state = S_PLACED;
                end else begin
                    w_rd_issue = 1'b1;
                    w_rd_addr  = AW'(r_count - CW'(1));
                    n_state    = S_BS_LAST;
                end
            end

            S_BS_LAST: begin
                if (w_gt) begin
                    n_at    = r_count;
                    n_state = S_PLACED;
                end else begin
                    n_low      = '0;
                    n_high     = $signed({2'b00, r_count}) - SW'(1);
                    n_mid      = (r_count - CW'(1)) >> 1;
                    w_rd_issue = 1'b1;
                    w_rd_addr  = AW'((r_count - CW'(1)) >> 1);
                    n_state    = S_BS_MID;
                end
            end

            S_BS_MID: begin
                if (w_eq) begin
                    n_at    = r_mid;
                    n_state = S_PLACED;
                end else if (w_nl <= w_nh) begin
                    n_low      = w_nl;
                    n_high     = w_nh;
                    n_mid      = w_nmid[CW-1:0];
                    w_rd_issue = 1'b1;
                    w_rd_addr  = w_nmid[AW-1:0];
                end else begin
                    // Search ran out: the place is just past the last probe if the key was above it
                    n_at    = w_gt ? (r_mid + CW'(1)) : r_mid;
                    n_state = S_PLACED;
                end
            end

            S_PLACED: begin
                if (r_at < r_count &&
                    !(r_kind == skt_pkg::KIND_INSERT && r_allow_dup)) begin
                    w_rd_issue = 1'b1;
                    w_rd_addr  = r_at[AW-1:0];
                    n_state    = S_PCMP;
                end else begin
                    n_state = S_MISS;
                end
            end

            S_PCMP: begin
                n_state = w_eq ? S_HIT : S_MISS;
            end

            S_SCAN: begin
                // Compare the entry read last cycle while the next read is in flight
                if (r_rd_valid && w_eq) begin
                    n_at    = CW'(r_rd_addr);
                    n_state = S_HIT;
                end else if (r_left != '0) begin
                    w_rd_issue = 1'b1;
                    w_rd_addr  = r_ptr;
                    n_ptr      = r_ptr + AW'(1);
                    n_left     = r_left - CW'(1);
                end else if (!r_rd_valid) begin
                    n_state = S_MISS;
                end
            end

            S_HIT: begin
                unique case (r_kind)
                    skt_pkg::KIND_INSERT: begin
                        n_done       = 1'b1;
                        n_rsp.status = skt_pkg::ST_DUP;
                        n_state      = S_IDLE;
                    end
                    skt_pkg::KIND_REMOVE_KEY: begin
                        n_left  = r_count - r_at - CW'(1);
                        n_ptr   = r_at[AW-1:0] + AW'(1);
                        n_state = S_SHIFT;
                    end
                    skt_pkg::KIND_FIND: begin
                        n_done      = 1'b1;
                        n_rsp.index = f_idx(r_at);
                        n_rsp.value = f_val(r_key);
                        n_state     = S_IDLE;
                    end
                    skt_pkg::KIND_BEFORE: begin
                        if (r_at == '0) begin
                            n_done       = 1'b1;
                            n_rsp.status = skt_pkg::ST_NOTFOUND;
                            n_state      = S_IDLE;
                        end else begin
                            n_at       = r_at - CW'(1);
                            w_rd_issue = 1'b1;
                            w_rd_addr  = r_at[AW-1:0] - AW'(1);
                            n_state    = S_RDV;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_MISS: begin
                if (r_kind == skt_pkg::KIND_INSERT) begin
                    if (r_count >= CAP) begin
                        n_done       = 1'b1;
                        n_rsp.status = skt_pkg::ST_FULL;
                        n_state      = S_IDLE;
                    end else begin
                        n_left  = r_count - r_at;
                        n_ptr   = AW'(r_count - CW'(1));
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_done       = 1'b1;
                    n_rsp.status = skt_pkg::ST_NOTFOUND;
                    n_state      = S_IDLE;
                end
            end

            S_SHIFT: begin
                // Insert moves entries up from the top down; removes move them down
                if (r_rd_valid) begin
                    w_we    = 1'b1;
                    w_waddr = (r_kind == skt_pkg::KIND_INSERT) ?
                              (r_rd_addr + AW'(1)) : (r_rd_addr - AW'(1));
                    w_wdata = w_rdata;
                end
                if (r_left != '0) begin
                    w_rd_issue = 1'b1;
                    w_rd_addr  = r_ptr;
                    n_ptr      = (r_kind == skt_pkg::KIND_INSERT) ?
                                 (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                    n_left     = r_left - CW'(1);
                end else if (!r_rd_valid) begin
                    n_done      = 1'b1;
                    n_rsp.index = f_idx(r_at);
                    n_state     = S_IDLE;
                    if (r_kind == skt_pkg::KIND_INSERT) begin
                        w_we    = 1'b1;
                        w_waddr = r_at[AW-1:0];
                        w_wdata = r_key;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_count = r_count - CW'(1);
                        if (r_kind == skt_pkg::KIND_REMOVE_KEY) begin
                            n_rsp.value = f_val(r_key);
                        end
                    end
                end
            end

            S_RDV: begin
                n_done      = 1'b1;
                n_rsp.index = f_idx(r_at);
                n_rsp.value = f_val(w_rdata);
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rsp.count = f_cnt(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_keep_sorted <= 1'b0;
            r_allow_dup   <= 1'b0;
            r_rd_valid    <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_valid <= w_rd_issue;
            r_done     <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    skt_pkg::CFG_KEEP_SORTED: r_keep_sorted <= i_cfg_data[0];
                    skt_pkg::CFG_ALLOW_DUP:   r_allow_dup   <= i_cfg_data[0];
                endcase
            end
        end
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_at      <= n_at;
        r_mid     <= n_mid;
        r_low     <= n_low;
        r_high    <= n_high;
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_rd_addr <= w_rd_addr;
        if (n_done) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* hw/rtl/skt_chk.sv */
// Port-level checker for the sorted key table, bound to the top level.
// Depends on skt_pkg.
module skt_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input skt_pkg::t_rsp o_rsp
);

    // An accepted request either finishes at once or holds the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request accepted but neither busy nor done");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("response strobe while still busy");

    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a response");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != skt_pkg::ST_OK) |->
        (o_rsp.index == '0 && o_rsp.value == '0))
        else $error("failed request returned nonzero index or value");

endmodule

bind sorted_key_table skt_chk u_skt_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);
